// File: src/rcs_pkg.sv
package rcs_pkg;

  localparam int unsigned NumCfgRegs = 7;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [31:0] FIXED_FILL_SEC = 32'd120;
  localparam logic [9:0]  PUMP_ON_LEVEL  = 10'd30;
  localparam logic [9:0]  PUMP_LOW_LEVEL = 10'd20;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'd0,
    ST_FILL1  = 4'd1,
    ST_LOOP1  = 4'd2,
    ST_DRAIN1 = 4'd4,
    ST_FILL2  = 4'd5,
    ST_LOOP2  = 4'd6,
    ST_DRAIN2 = 4'd7,
    ST_FINISH = 4'd8,
    ST_FAULT  = 4'd15
  } step_e;

  typedef enum logic [2:0] {
    CFG_MODE   = 3'd0,
    CFG_TOTAL  = 3'd1,
    CFG_VOL1   = 3'd2,
    CFG_VOL2   = 3'd3,
    CFG_LOOPS  = 3'd4,
    CFG_ON     = 3'd5,
    CFG_OFF    = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_ON   = 2'd1,
    ACT_OFF  = 2'd2
  } act_e;

  typedef enum logic [1:0] {
    RUN_IDLE  = 2'd0,
    RUN_BUSY  = 2'd1,
    RUN_DONE  = 2'd2,
    RUN_FAULT = 2'd3
  } run_e;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_START = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    FILL_BUSY    = 2'd0,
    FILL_DONE    = 2'd1,
    FILL_TIMEOUT = 2'd2
  } fill_e;

  typedef struct packed {
    logic        command;
    logic [31:0] now_sec;
    logic [31:0] pause_sec;
    logic [9:0]  water_level;
    logic [1:0]  fill_status;
    logic        drain_done;
    logic        pump_running;
    logic        cooling_running;
  } in_t;

  typedef struct packed {
    act_e        pump_action;
    act_e        cooling_action;
    act_e        valve_action;
    logic [9:0]  fill_target;
    logic        drain_request;
    logic [15:0] time_left;
    logic        time_left_changed;
    run_e        run_status;
    logic        stop_all;
  } out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic        program_mode;
    logic [15:0] total_time;
    logic [9:0]  first_volume;
    logic [9:0]  second_volume;
    logic [7:0]  loop_count;
    logic [15:0] on_seconds;
    logic [15:0] off_seconds;
  } cfg_t;

endpackage

// File: src/rcs_stream_if.sv
interface rcs_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/rcs_cfg_regs.sv
module rcs_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  rcs_stream_if.sink         cfg_i,
  output rcs_pkg::cfg_t      cfg_o
);

  rcs_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.data.index)
        rcs_pkg::CFG_MODE:  cfg_d.program_mode  = cfg_i.data.data[0];
        rcs_pkg::CFG_TOTAL: cfg_d.total_time    = cfg_i.data.data;
        rcs_pkg::CFG_VOL1:  cfg_d.first_volume  = cfg_i.data.data[9:0];
        rcs_pkg::CFG_VOL2:  cfg_d.second_volume = cfg_i.data.data[9:0];
        rcs_pkg::CFG_LOOPS: cfg_d.loop_count    = cfg_i.data.data[7:0];
        rcs_pkg::CFG_ON:    cfg_d.on_seconds    = cfg_i.data.data;
        rcs_pkg::CFG_OFF:   cfg_d.off_seconds   = cfg_i.data.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: src/rcs_core.sv
module rcs_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           advance_i,
  input  rcs_pkg::in_t   item_i,
  input  rcs_pkg::cfg_t  cfg_i,
  output rcs_pkg::out_t  res_o
);

  rcs_pkg::step_e step_q, step_d;
  logic [7:0]     loop_idx_q, loop_idx_d;
  logic [31:0]    prog_start_q, prog_start_d;
  logic [31:0]    phase_start_q, phase_start_d;
  logic [15:0]    last_left_q, last_left_d;

  logic [31:0] net_sec, el_prog, el_phase;
  logic [15:0] tl;
  logic [23:0] on_prod, off_prod;
  logic [7:0]  idx_m1;
  logic [31:0] off_ext, bound_on, bound_off;
  logic        alt;

  assign alt      = cfg_i.program_mode;
  assign net_sec  = item_i.now_sec - item_i.pause_sec;
  assign el_prog  = net_sec - prog_start_q;
  assign el_phase = net_sec - phase_start_q;
  assign tl       = cfg_i.total_time - el_prog[15:0];

  // window ends: on*i + off*(i-1) and (on+off)*i, mod 2^32; i = 0 gives -off and 0
  assign idx_m1    = loop_idx_q - 8'd1;
  assign on_prod   = {8'd0, cfg_i.on_seconds} * {16'd0, loop_idx_q};
  assign off_prod  = {8'd0, cfg_i.off_seconds} * {16'd0, idx_m1};
  assign off_ext   = {16'd0, cfg_i.off_seconds};
  assign bound_on  = {8'd0, on_prod}
                   + ((loop_idx_q == 8'd0) ? (32'd0 - off_ext) : {8'd0, off_prod});
  assign bound_off = bound_on + off_ext;

  always_comb begin
    logic       show_en, fix_en, do_fill, fill_first, do_loop;
    logic       lp_cool, lp_show, lp_exit_pump, was_on;
    logic [15:0] fix_val;
    logic [9:0] fill_tgt;
    rcs_pkg::step_e lp_next;

    show_en      = 1'b0;
    fix_en       = 1'b0;
    fix_val      = 16'd0;
    do_fill      = 1'b0;
    fill_first   = 1'b0;
    fill_tgt     = 10'd0;
    do_loop      = 1'b0;
    lp_cool      = 1'b0;
    lp_show      = 1'b0;
    lp_exit_pump = 1'b0;
    lp_next      = rcs_pkg::ST_DRAIN1;
    was_on       = 1'b0;

    res_o         = '0;
    step_d        = step_q;
    loop_idx_d    = loop_idx_q;
    prog_start_d  = prog_start_q;
    phase_start_d = phase_start_q;
    last_left_d   = last_left_q;

    if (item_i.command == rcs_pkg::CMD_START) begin
      loop_idx_d       = 8'd0;
      prog_start_d     = alt ? item_i.now_sec : 32'd0;
      step_d           = rcs_pkg::ST_FILL1;
      res_o.run_status = rcs_pkg::RUN_BUSY;
    end else begin
      res_o.run_status = (step_q == rcs_pkg::ST_IDLE) ? rcs_pkg::RUN_IDLE : rcs_pkg::RUN_BUSY;
      case (step_q)
        rcs_pkg::ST_FILL1: begin
          if (alt) begin
            res_o.valve_action = rcs_pkg::ACT_ON;
            step_d             = rcs_pkg::ST_LOOP1;
          end else begin
            do_fill    = 1'b1;
            fill_first = 1'b1;
            fill_tgt   = cfg_i.first_volume;
            fix_en     = 1'b1;
            fix_val    = cfg_i.total_time;
          end
        end
        rcs_pkg::ST_LOOP1: begin
          if (alt) begin
            show_en = 1'b1;
            if (el_prog < rcs_pkg::FIXED_FILL_SEC) begin
              if (item_i.water_level > rcs_pkg::PUMP_ON_LEVEL && !item_i.pump_running)
                res_o.pump_action = rcs_pkg::ACT_ON;
              if (item_i.water_level < rcs_pkg::PUMP_LOW_LEVEL && item_i.pump_running)
                res_o.pump_action = rcs_pkg::ACT_OFF;
            end else begin
              res_o.valve_action = rcs_pkg::ACT_OFF;
              step_d             = rcs_pkg::ST_DRAIN1;
            end
          end else begin
            do_loop      = 1'b1;
            lp_cool      = 1'b1;
            lp_show      = 1'b1;
            lp_exit_pump = 1'b1;
            lp_next      = rcs_pkg::ST_DRAIN1;
          end
        end
        rcs_pkg::ST_DRAIN1: begin
          show_en             = 1'b1;
          res_o.drain_request = 1'b1;
          if (item_i.drain_done) step_d = rcs_pkg::ST_FILL2;
        end
        rcs_pkg::ST_FILL2: begin
          do_fill  = 1'b1;
          fill_tgt = cfg_i.second_volume;
          show_en  = !alt;
        end
        rcs_pkg::ST_LOOP2: begin
          do_loop = 1'b1;
          lp_cool = !alt;
          lp_show = !alt;
          lp_next = rcs_pkg::ST_DRAIN2;
        end
        rcs_pkg::ST_DRAIN2: begin
          show_en             = 1'b1;
          res_o.drain_request = 1'b1;
          if (item_i.drain_done) begin
            fix_en = 1'b1;
            step_d = rcs_pkg::ST_FINISH;
          end
        end
        rcs_pkg::ST_FINISH: begin
          step_d           = rcs_pkg::ST_IDLE;
          prog_start_d     = 32'd0;
          res_o.run_status = rcs_pkg::RUN_DONE;
        end
        rcs_pkg::ST_FAULT: begin
          step_d           = rcs_pkg::ST_IDLE;
          prog_start_d     = 32'd0;
          res_o.stop_all   = 1'b1;
          res_o.run_status = rcs_pkg::RUN_FAULT;
        end
        default: ;
      endcase

      if (do_fill) begin
        res_o.fill_target = fill_tgt;
        if (item_i.fill_status == rcs_pkg::FILL_DONE) begin
          phase_start_d = net_sec;
          if (fill_first) begin
            prog_start_d = net_sec;
            step_d       = rcs_pkg::ST_LOOP1;
          end else begin
            step_d = rcs_pkg::ST_LOOP2;
          end
          loop_idx_d = 8'd1;
        end else if (item_i.fill_status == rcs_pkg::FILL_TIMEOUT) begin
          step_d = rcs_pkg::ST_FAULT;
        end else if (item_i.water_level > rcs_pkg::PUMP_LOW_LEVEL && !item_i.pump_running) begin
          res_o.pump_action = rcs_pkg::ACT_ON;
        end
      end

      if (do_loop) begin
        if (loop_idx_q <= cfg_i.loop_count) begin
          if (el_phase < bound_on) begin
            if (!item_i.pump_running) res_o.pump_action = rcs_pkg::ACT_ON;
            if (lp_cool && !item_i.cooling_running) res_o.cooling_action = rcs_pkg::ACT_ON;
            show_en = 1'b1;
          end else if (el_phase < bound_off) begin
            was_on = item_i.pump_running;
            if (was_on) res_o.pump_action = rcs_pkg::ACT_OFF;
            if (lp_cool && item_i.cooling_running) res_o.cooling_action = rcs_pkg::ACT_OFF;
            show_en = lp_show || was_on;
          end else begin
            loop_idx_d = loop_idx_q + 8'd1;
          end
        end else begin
          if (lp_exit_pump && !item_i.pump_running) res_o.pump_action = rcs_pkg::ACT_ON;
          step_d     = lp_next;
          loop_idx_d = 8'd1;
        end
      end

      // display refresh only on change; fixed values override and leave the shadow alone
      if (show_en && tl != last_left_q) begin
        last_left_d             = tl;
        res_o.time_left         = tl;
        res_o.time_left_changed = 1'b1;
      end
      if (fix_en) begin
        res_o.time_left         = fix_val;
        res_o.time_left_changed = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q        <= rcs_pkg::ST_IDLE;
      loop_idx_q    <= '0;
      prog_start_q  <= '0;
      phase_start_q <= '0;
      last_left_q   <= '0;
    end else if (advance_i) begin
      step_q        <= step_d;
      loop_idx_q    <= loop_idx_d;
      prog_start_q  <= prog_start_d;
      phase_start_q <= phase_start_d;
      last_left_q   <= last_left_d;
    end
  end

endmodule

// File: src/rinse_cycle_sequencer.sv
// Rinse program sequencer. Each accepted word (start command or one-second tick) yields
// exactly one result word. Throughput is one word per clock while the output side is not
// stalled; a word is captured in the input register, evaluated against the program state
// combinationally (elapsed-time subtracts, two 16x8 products for the loop-window bounds,
// and the compares), and the result is registered in the output register, from which it
// is offered. A stalled output holds the input register, which then takes no new word.
// Configuration writes are always taken and are meant to happen only while no word is in
// flight.
module rinse_cycle_sequencer (
  input  logic         clk_i,
  input  logic         rst_ni,
  rcs_stream_if.sink   in_i,
  rcs_stream_if.sink   cfg_i,
  rcs_stream_if.source out_o
);

  rcs_pkg::cfg_t cfg;
  rcs_pkg::in_t  in_q;
  rcs_pkg::out_t res, out_q;
  logic          in_vld_q, out_vld_q, advance;

  assign advance     = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready  = !in_vld_q || advance;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  rcs_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  rcs_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (in_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) in_vld_q <= in_i.valid;
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) in_q <= in_i.data;
    if (advance) out_q <= res;
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rcs_pkg::*;

  typedef enum int {IdleNone, IdleSrc, IdleSink, IdleBoth} idle_e;

  // fill unit code with no defined meaning, the block treats it as still filling
  localparam logic [1:0] FillUnused = 2'd3;

  logic clk_i;
  logic rst_ni;

  rcs_stream_if #(.payload_t(in_t))     in_if ();
  rcs_stream_if #(.payload_t(cfg_wr_t)) cfg_if ();
  rcs_stream_if #(.payload_t(out_t))    out_if ();

  rinse_cycle_sequencer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  in_t         cmd_words[$];
  out_t        pending_results[$];
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_errors;
  idle_e       idle_mode;
  logic [31:0] sim_now;
  logic [31:0] sim_pause;

  // shadow of the sequencer: registers and program state
  cfg_t        rinse_cfg;
  logic [3:0]  seq_step;
  logic [7:0]  loop_idx;
  logic [31:0] prog_start;
  logic [31:0] phase_start;
  logic [15:0] shown_left;
  out_t        rinse_out;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic note_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    n_errors++;
  endtask

  task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) note_error($sformatf("%s: exp %0d got %0d", name, want, got));
  endtask

  // ---------------------------------------------------------------- prediction

  function automatic void show_time(input logic [31:0] now, input logic [31:0] pause);
    logic [31:0] full;
    full = {16'd0, rinse_cfg.total_time} - (now - prog_start - pause);
    if (full[15:0] != shown_left) begin
      shown_left = full[15:0];
      rinse_out.time_left = full[15:0];
      rinse_out.time_left_changed = 1'b1;
    end
  endfunction

  function automatic void fill_phase(input logic [9:0] target, input in_t w, input bit first);
    rinse_out.fill_target = target;
    if (w.fill_status == FILL_DONE) begin
      phase_start = w.now_sec - w.pause_sec;
      if (first) begin
        prog_start = phase_start;
        seq_step = ST_LOOP1;
      end else begin
        seq_step = ST_LOOP2;
      end
      loop_idx = 8'd1;
    end else if (w.fill_status == FILL_TIMEOUT) begin
      seq_step = ST_FAULT;
    end else if (w.water_level > PUMP_LOW_LEVEL && !w.pump_running) begin
      rinse_out.pump_action = ACT_ON;
    end
  endfunction

  function automatic void loop_phase(input in_t w, input bit with_cool, input bit always_show,
                                     input bit pump_on_exit, input logic [3:0] next_step);
    logic [31:0] el;
    logic [31:0] idx;
    logic [31:0] on32;
    logic [31:0] off32;
    logic [31:0] on_end;
    logic [31:0] off_end;
    el    = w.now_sec - phase_start - w.pause_sec;
    idx   = {24'd0, loop_idx};
    on32  = {16'd0, rinse_cfg.on_seconds};
    off32 = {16'd0, rinse_cfg.off_seconds};
    if (loop_idx <= rinse_cfg.loop_count) begin
      // index 0 (after a wrap) makes the on-window bound wrap too
      on_end  = on32 * idx + off32 * (idx - 32'd1);
      off_end = (on32 + off32) * idx;
      if (el < on_end) begin
        if (!w.pump_running) rinse_out.pump_action = ACT_ON;
        if (with_cool && !w.cooling_running) rinse_out.cooling_action = ACT_ON;
        show_time(w.now_sec, w.pause_sec);
      end else if (el < off_end) begin
        if (w.pump_running) rinse_out.pump_action = ACT_OFF;
        if (with_cool && w.cooling_running) rinse_out.cooling_action = ACT_OFF;
        if (always_show || w.pump_running) show_time(w.now_sec, w.pause_sec);
      end else begin
        loop_idx = loop_idx + 8'd1;
      end
    end else begin
      if (pump_on_exit && !w.pump_running) rinse_out.pump_action = ACT_ON;
      seq_step = next_step;
      loop_idx = 8'd1;
    end
  endfunction

  function automatic void drain_phase(input in_t w, input bit last);
    show_time(w.now_sec, w.pause_sec);
    rinse_out.drain_request = 1'b1;
    if (w.drain_done) begin
      if (last) begin
        // display forced to zero, shown_left kept
        rinse_out.time_left = 16'd0;
        rinse_out.time_left_changed = 1'b1;
        seq_step = ST_FINISH;
      end else begin
        seq_step = ST_FILL2;
      end
    end
  endfunction

  function automatic out_t next_rinse_result(input in_t w);
    logic alt;
    alt = rinse_cfg.program_mode;
    rinse_out = '0;
    if (w.command == CMD_START) begin
      loop_idx = 8'd0;
      prog_start = alt ? w.now_sec : 32'd0;
      seq_step = ST_FILL1;
      rinse_out.run_status = RUN_BUSY;
    end else begin
      rinse_out.run_status = (seq_step == ST_IDLE) ? RUN_IDLE : RUN_BUSY;
      case (seq_step)
        ST_FILL1: begin
          if (alt) begin
            rinse_out.valve_action = ACT_ON;
            seq_step = ST_LOOP1;
          end else begin
            fill_phase(rinse_cfg.first_volume, w, 1'b1);
            rinse_out.time_left = rinse_cfg.total_time;
            rinse_out.time_left_changed = 1'b1;
          end
        end
        ST_LOOP1: begin
          if (alt) begin
            show_time(w.now_sec, w.pause_sec);
            if ((w.now_sec - prog_start - w.pause_sec) < FIXED_FILL_SEC) begin
              if (w.water_level > PUMP_ON_LEVEL && !w.pump_running)
                rinse_out.pump_action = ACT_ON;
              if (w.water_level < PUMP_LOW_LEVEL && w.pump_running)
                rinse_out.pump_action = ACT_OFF;
            end else begin
              rinse_out.valve_action = ACT_OFF;
              seq_step = ST_DRAIN1;
            end
          end else begin
            loop_phase(w, 1'b1, 1'b1, 1'b1, ST_DRAIN1);
          end
        end
        ST_DRAIN1: drain_phase(w, 1'b0);
        ST_FILL2: begin
          fill_phase(rinse_cfg.second_volume, w, 1'b0);
          if (!alt) show_time(w.now_sec, w.pause_sec);
        end
        ST_LOOP2: loop_phase(w, !alt, !alt, 1'b0, ST_DRAIN2);
        ST_DRAIN2: drain_phase(w, 1'b1);
        ST_FINISH: begin
          seq_step = ST_IDLE;
          prog_start = 32'd0;
          rinse_out.run_status = RUN_DONE;
        end
        ST_FAULT: begin
          seq_step = ST_IDLE;
          prog_start = 32'd0;
          rinse_out.stop_all = 1'b1;
          rinse_out.run_status = RUN_FAULT;
        end
        default: ;
      endcase
    end
    return rinse_out;
  endfunction

  // ---------------------------------------------------------------- driver

  function automatic bit send_ok();
    case (idle_mode)
      IdleSrc:  return $urandom_range(99) >= 78;
      IdleBoth: return $urandom_range(99) >= 19;
      default:  return 1'b1;
    endcase
  endfunction

  function automatic bit sink_ok();
    case (idle_mode)
      IdleSink: return $urandom_range(99) >= 78;
      IdleBoth: return $urandom_range(99) >= 19;
      default:  return 1'b1;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
    end else if (!in_if.valid || in_if.ready) begin
      if (cmd_words.size() != 0 && send_ok()) begin
        in_if.data  <= cmd_words.pop_front();
        in_if.valid <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_if.ready <= 1'b0;
    else out_if.ready <= sink_ok();
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i or negedge rst_ni) begin : mon
    out_t want;
    if (!rst_ni) begin
      rinse_cfg   = '0;
      seq_step    = ST_IDLE;
      loop_idx    = 8'd0;
      prog_start  = 32'd0;
      phase_start = 32'd0;
      shown_left  = 16'd0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.data.index)
          CFG_MODE:  rinse_cfg.program_mode  = cfg_if.data.data[0];
          CFG_TOTAL: rinse_cfg.total_time    = cfg_if.data.data;
          CFG_VOL1:  rinse_cfg.first_volume  = cfg_if.data.data[9:0];
          CFG_VOL2:  rinse_cfg.second_volume = cfg_if.data.data[9:0];
          CFG_LOOPS: rinse_cfg.loop_count    = cfg_if.data.data[7:0];
          CFG_ON:    rinse_cfg.on_seconds    = cfg_if.data.data;
          CFG_OFF:   rinse_cfg.off_seconds   = cfg_if.data.data;
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          note_error("result word with nothing expected");
        end else begin
          want = pending_results.pop_front();
          cmp_field("pump_action", want.pump_action, out_if.data.pump_action);
          cmp_field("cooling_action", want.cooling_action, out_if.data.cooling_action);
          cmp_field("valve_action", want.valve_action, out_if.data.valve_action);
          cmp_field("fill_target", want.fill_target, out_if.data.fill_target);
          cmp_field("drain_request", want.drain_request, out_if.data.drain_request);
          cmp_field("time_left", want.time_left, out_if.data.time_left);
          cmp_field("time_left_changed", want.time_left_changed,
                    out_if.data.time_left_changed);
          cmp_field("run_status", want.run_status, out_if.data.run_status);
          cmp_field("stop_all", want.stop_all, out_if.data.stop_all);
          n_checked++;
        end
      end
      if (in_if.valid && in_if.ready) pending_results.push_back(next_rinse_result(in_if.data));
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic in_t mk(input cmd_e cmd, input logic [31:0] now, input logic [31:0] pause,
                             input logic [9:0] lvl, input logic [1:0] fs, input logic dd,
                             input logic pump, input logic cool);
    in_t w;
    w.command         = cmd;
    w.now_sec         = now;
    w.pause_sec       = pause;
    w.water_level     = lvl;
    w.fill_status     = fs;
    w.drain_done      = dd;
    w.pump_running    = pump;
    w.cooling_running = cool;
    return w;
  endfunction

  function automatic in_t random_tick();
    in_t w;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) sim_now += 32'd1;
    else if (r < 90) sim_now += $urandom_range(10, 2);
    else if (r < 98) sim_now += $urandom_range(60, 11);
    else sim_now = $urandom();
    if ($urandom_range(99) < 6) sim_pause += $urandom_range(5, 1);
    w.command   = CMD_TICK;
    w.now_sec   = sim_now;
    w.pause_sec = sim_pause;
    // hover around the pump thresholds a good part of the time
    w.water_level = ($urandom_range(99) < 35) ? 10'($urandom_range(33, 17))
                                              : 10'($urandom_range(1023));
    r = $urandom_range(99);
    if (r < 78) w.fill_status = FILL_BUSY;
    else if (r < 92) w.fill_status = FILL_DONE;
    else if (r < 96) w.fill_status = FILL_TIMEOUT;
    else w.fill_status = FillUnused;
    w.drain_done      = $urandom_range(99) < 20;
    w.pump_running    = 1'($urandom_range(1));
    w.cooling_running = 1'($urandom_range(1));
    return w;
  endfunction

  task automatic queue_word(input in_t w);
    cmd_words.push_back(w);
    n_sent++;
  endtask

  task automatic wait_drained();
    while (cmd_words.size() != 0 || n_checked != n_sent) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= {idx, val};
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_all(input logic mode, input logic [15:0] total, input logic [9:0] vol1,
                         input logic [9:0] vol2, input logic [7:0] loops,
                         input logic [15:0] on_s, input logic [15:0] off_s);
    cfg_write(CFG_MODE, {15'd0, mode});
    cfg_write(CFG_TOTAL, total);
    cfg_write(CFG_VOL1, {6'd0, vol1});
    cfg_write(CFG_VOL2, {6'd0, vol2});
    cfg_write(CFG_LOOPS, {8'd0, loops});
    cfg_write(CFG_ON, on_s);
    cfg_write(CFG_OFF, off_s);
  endtask

  // starts come mostly when the program sits idle; restart_pm adds starts mid-run
  task automatic run_random(input int unsigned count, input int unsigned restart_pm);
    in_t w;
    for (int unsigned k = 0; k < count; k++) begin
      @(negedge clk_i);
      while (cmd_words.size() >= 4) @(negedge clk_i);
      w = random_tick();
      if ((seq_step == ST_IDLE && $urandom_range(99) < 70) || $urandom_range(999) < restart_pm)
        w.command = CMD_START;
      queue_word(w);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    idle_mode = IdleNone;
    n_sent    = 0;
    n_checked = 0;
    n_errors  = 0;
    sim_now   = $urandom();
    sim_pause = $urandom();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: one standard program end to end, restart, fill timeout
    set_all(1'b0, 16'hFFFF, 10'h3FF, 10'h000, 8'd1, 16'd1, 16'd1);
    @(negedge clk_i);
    queue_word(mk(CMD_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF, FillUnused, 1, 1, 1));
    queue_word(mk(CMD_TICK, 32'd0, 32'd0, 10'd0, FILL_BUSY, 0, 0, 0));
    queue_word(mk(CMD_START, 32'd1000, 32'd10, 10'd0, FILL_BUSY, 0, 0, 0));
    queue_word(mk(CMD_TICK, 32'd1001, 32'd10, 10'h3FF, FillUnused, 0, 0, 0));
    queue_word(mk(CMD_TICK, 32'd1002, 32'd10, 10'd20, FILL_BUSY, 0, 0, 0));
    queue_word(mk(CMD_TICK, 32'd1003, 32'd10, 10'd21, FILL_DONE, 0, 1, 0));
    queue_word(mk(CMD_TICK, 32'd1003, 32'd10, 10'd50, FILL_BUSY, 0, 0, 0));
    queue_word(mk(CMD_TICK, 32'd1004, 32'd10, 10'd50, FILL_BUSY, 0, 1, 1));
    queue_word(mk(CMD_TICK, 32'd1005, 32'd10, 10'd50, FILL_BUSY, 0, 0, 0));
    queue_word(mk(CMD_TICK, 32'd1006, 32'd10, 10'd50, FILL_BUSY, 0, 0, 0));
    queue_word(mk(CMD_TICK, 32'd1007, 32'd10, 10'd50, FILL_BUSY, 0, 0, 0));
    queue_word(mk(CMD_TICK, 32'd1008, 32'd10, 10'd50, FILL_BUSY, 1, 0, 0));
    queue_word(mk(CMD_TICK, 32'd1009, 32'd10, 10'd25, FILL_BUSY, 0, 0, 0));
    queue_word(mk(CMD_TICK, 32'd1010, 32'd10, 10'd25, FILL_DONE, 0, 0, 0));
    queue_word(mk(CMD_TICK, 32'd1010, 32'd10, 10'd25, FILL_BUSY, 0, 0, 0));
    queue_word(mk(CMD_TICK, 32'd1012, 32'd10, 10'd25, FILL_BUSY, 0, 1, 1));
    queue_word(mk(CMD_TICK, 32'd1013, 32'd10, 10'd25, FILL_BUSY, 0, 0, 0));
    queue_word(mk(CMD_TICK, 32'd1014, 32'd10, 10'd25, FILL_BUSY, 1, 0, 0));
    queue_word(mk(CMD_TICK, 32'd1015, 32'd10, 10'd25, FILL_BUSY, 0, 0, 0));
    queue_word(mk(CMD_START, 32'd2000, 32'd0, 10'd0, FILL_BUSY, 0, 0, 0));
    queue_word(mk(CMD_START, 32'd2001, 32'd0, 10'd0, FILL_BUSY, 0, 0, 0));
    queue_word(mk(CMD_TICK, 32'd2002, 32'd0, 10'd0, FILL_TIMEOUT, 0, 0, 0));
    queue_word(mk(CMD_TICK, 32'd2003, 32'd0, 10'd0, FILL_BUSY, 0, 0, 0));
    wait_drained();

    // alternate start, then switch to standard mid-program: loop index is still 0
    cfg_write(CFG_MODE, 16'd1);
    @(negedge clk_i);
    queue_word(mk(CMD_START, 32'd5000, 32'd0, 10'd0, FILL_BUSY, 0, 0, 0));
    queue_word(mk(CMD_TICK, 32'd5001, 32'd0, 10'd0, FILL_BUSY, 0, 0, 0));
    wait_drained();
    cfg_write(CFG_MODE, 16'd0);
    @(negedge clk_i);
    queue_word(mk(CMD_TICK, 32'd5003, 32'd0, 10'd0, FILL_BUSY, 0, 0, 0));
    queue_word(mk(CMD_TICK, 32'd5004, 32'd0, 10'd0, FILL_BUSY, 0, 1, 1));
    wait_drained();

    for (int p = 1; p <= 8; p++) begin
      idle_mode = idle_e'(p % 4);
      case (p)
        3, 6: cfg_write(CFG_MODE, {15'd0, ~rinse_cfg.program_mode});
        4: set_all(1'b0, 16'hFFFF, 10'h3FF, 10'h3FF, 8'hFF, 16'd0, 16'd0);
        5: set_all(1'b1, 16'd0, 10'd0, 10'd0, 8'd1, 16'hFFFF, 16'hFFFF);
        default: set_all(1'($urandom_range(1)), 16'($urandom_range(65535)),
                         10'($urandom_range(1023)), 10'($urandom_range(1023)),
                         8'($urandom_range(3)), 16'($urandom_range(4)),
                         16'($urandom_range(4)));
      endcase
      // long run of the 255-loop setting so the loop index wraps
      if (p == 4) run_random(320, 0);
      else run_random((p < 3) ? 60 : ((p < 7) ? 40 : 45), 5);
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (pending_results.size() != 0) note_error("expected results never arrived");
    if (n_errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
